[src/ddi_pkg.sv]
package ddi_pkg;

    localparam int CAPACITY = 1024;
    localparam int WORD_W   = 64;
    localparam int KEY_W    = 4 * WORD_W;
    localparam int ID_W     = 10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    typedef struct packed {
        logic            is_duplicate;
        logic [ID_W-1:0] chunk_id;
        logic            table_full;
    } result_t;

endpackage

[src/ddi_digest_if.sv]
interface ddi_digest_if;
    logic                        valid;
    logic                        ready;
    logic [ddi_pkg::WORD_W-1:0]  digest_w0;
    logic [ddi_pkg::WORD_W-1:0]  digest_w1;
    logic [ddi_pkg::WORD_W-1:0]  digest_w2;
    logic [ddi_pkg::WORD_W-1:0]  digest_w3;

    modport source (output valid, digest_w0, digest_w1, digest_w2, digest_w3, input ready);
    modport sink   (input valid, digest_w0, digest_w1, digest_w2, digest_w3, output ready);
endinterface

[src/ddi_result_if.sv]
interface ddi_result_if;
    logic                       valid;
    logic                       ready;
    logic                       is_duplicate;
    logic [ddi_pkg::ID_W-1:0]   chunk_id;
    logic                       table_full;

    modport source (output valid, is_duplicate, chunk_id, table_full, input ready);
    modport sink   (input valid, is_duplicate, chunk_id, table_full, output ready);
endinterface

[src/digest_dedup_index.sv]
// Deduplication index for 256-bit chunk digests. Each digest transaction is
// compared against the stored digests in order of arrival, one entry per cycle,
// up to the first hit, read from a single 256-bit wide key RAM. A hit returns the
// id assigned at first sight with is_duplicate set; a miss stores the digest at
// the next free id; a miss with all CAPACITY entries in use returns table_full
// with chunk_id 0 and stores nothing. One digest is handled at a time, and the
// search is bound by the one-read-per-cycle RAM scan; with the table empty no
// scan is made. The result sits in an output register, so the next digest can
// be taken while it waits. chunk_id carries the low 10 bits of the id. Reset
// clears the state, the fill count and the output valid; no clearing pass is
// needed.
module digest_dedup_index #(
    parameter int CAPACITY = ddi_pkg::CAPACITY
) (
    input  logic          clk,
    input  logic          rst_n,
    ddi_digest_if.sink    digest,
    ddi_result_if.source  result
);

    localparam int AW = $clog2(CAPACITY);

    logic                       ram_we;
    logic [AW-1:0]              ram_wr_addr;
    logic [ddi_pkg::KEY_W-1:0]  ram_wr_data;
    logic                       ram_re;
    logic [AW-1:0]              ram_rd_addr;
    logic [ddi_pkg::KEY_W-1:0]  ram_rd_data;

    ddi_ram #(
        .WIDTH (ddi_pkg::KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .re      (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ddi_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .digest      (digest),
        .result      (result),
        .ram_we      (ram_we),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_re      (ram_re),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    a_dup_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.is_duplicate && result.table_full))
        else $error("duplicate and table_full both set");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready) |=> !digest.ready)
        else $error("new digest taken while a search is in progress");

    a_store_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (result.valid && !result.is_duplicate && !result.table_full))
        else $error("stored digest without a new-id result");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("key RAM written during a scan read");

endmodule

[src/ddi_ram.sv]
module ddi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             re,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/ddi_ctrl.sv]
module ddi_ctrl #(
    parameter int CAPACITY = ddi_pkg::CAPACITY,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ddi_digest_if.sink                 digest,
    ddi_result_if.source               result,
    output logic                       ram_we,
    output logic [AW-1:0]              ram_wr_addr,
    output logic [ddi_pkg::KEY_W-1:0]  ram_wr_data,
    output logic                       ram_re,
    output logic [AW-1:0]              ram_rd_addr,
    input  logic [ddi_pkg::KEY_W-1:0]  ram_rd_data
);

    ddi_pkg::state_t            state_reg, state_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic [CW-1:0]              used_reg, used_next;
    logic [ddi_pkg::KEY_W-1:0]  key_reg, key_next;
    logic                       hit_reg, hit_next;
    logic [AW-1:0]              hit_idx_reg, hit_idx_next;
    logic                       out_valid_reg, out_valid_next;
    ddi_pkg::result_t           out_data_reg, out_data_next;

    logic                       accept;
    logic                       match;
    logic                       last;
    logic                       out_free;
    logic [AW-1:0]              ptr_inc;
    logic [AW+ddi_pkg::ID_W-1:0] hit_id_ext;
    logic [CW+ddi_pkg::ID_W-1:0] new_id_ext;

    assign accept     = digest.valid && digest.ready;
    assign match      = (ram_rd_data == key_reg);
    assign last       = ((CW'(ptr_reg) + CW'(1)) == used_reg);
    assign out_free   = !out_valid_reg || result.ready;
    assign ptr_inc    = ptr_reg + AW'(1);
    assign hit_id_ext = {{ddi_pkg::ID_W{1'b0}}, hit_idx_reg};
    assign new_id_ext = {{ddi_pkg::ID_W{1'b0}}, used_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ddi_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (used_reg == '0) ? ddi_pkg::S_DECIDE : ddi_pkg::S_SCAN;
                end
            end
            ddi_pkg::S_SCAN:
            begin
                if (match || last)
                begin
                    state_next = ddi_pkg::S_DECIDE;
                end
            end
            ddi_pkg::S_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = ddi_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ddi_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        digest.ready   = 1'b0;
        ptr_next       = ptr_reg;
        used_next      = used_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_wr_addr    = used_reg[AW-1:0];
        ram_wr_data    = key_reg;
        ram_re         = 1'b0;
        ram_rd_addr    = '0;
        case (state_reg)
            ddi_pkg::S_IDLE:
            begin
                digest.ready = 1'b1;
                if (accept)
                begin
                    key_next = {digest.digest_w3, digest.digest_w2,
                                digest.digest_w1, digest.digest_w0};
                    ptr_next = '0;
                    hit_next = 1'b0;
                    ram_re   = 1'b1;
                end
            end
            ddi_pkg::S_SCAN:
            begin
                // read data belongs to ptr_reg; fetch the next entry ahead
                ram_re      = 1'b1;
                ram_rd_addr = ptr_inc;
                if (match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = ptr_reg;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end
            ddi_pkg::S_DECIDE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (hit_reg)
                    begin
                        out_data_next.is_duplicate = 1'b1;
                        out_data_next.chunk_id     = hit_id_ext[ddi_pkg::ID_W-1:0];
                        out_data_next.table_full   = 1'b0;
                    end
                    else if (used_reg == CW'(CAPACITY))
                    begin
                        out_data_next.is_duplicate = 1'b0;
                        out_data_next.chunk_id     = '0;
                        out_data_next.table_full   = 1'b1;
                    end
                    else
                    begin
                        // store the new digest in the next free slot
                        ram_we                     = 1'b1;
                        used_next                  = used_reg + CW'(1);
                        out_data_next.is_duplicate = 1'b0;
                        out_data_next.chunk_id     = new_id_ext[ddi_pkg::ID_W-1:0];
                        out_data_next.table_full   = 1'b0;
                    end
                end
            end
            default:
            begin
                digest.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ddi_pkg::S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        key_reg      <= key_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        out_data_reg <= out_data_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.is_duplicate = out_data_reg.is_duplicate;
    assign result.chunk_id     = out_data_reg.chunk_id;
    assign result.table_full   = out_data_reg.table_full;

endmodule

[tb/digest_dedup_index_tb.sv]
module digest_dedup_index_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS = 1480;
    localparam int unsigned LIMIT_CYCLES = 5_000_000;

    localparam logic [ddi_pkg::WORD_W-1:0] W_ZERO  = 64'h0000_0000_0000_0000;
    localparam logic [ddi_pkg::WORD_W-1:0] W_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [ddi_pkg::WORD_W-1:0] W_ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [ddi_pkg::WORD_W-1:0] W_ALT_5 = 64'h5555_5555_5555_5555;
    localparam logic [ddi_pkg::WORD_W-1:0] W_LOW1  = 64'h0000_0000_0000_0001;
    localparam logic [ddi_pkg::WORD_W-1:0] W_TOP1  = 64'h8000_0000_0000_0000;
    localparam logic [ddi_pkg::WORD_W-1:0] W_NOLOW = 64'hFFFF_FFFF_FFFF_FFFE;
    localparam logic [ddi_pkg::WORD_W-1:0] W_NOTOP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ddi_pkg::WORD_W-1:0] W_MIX_A = 64'h0123_4567_89AB_CDEF;
    localparam logic [ddi_pkg::WORD_W-1:0] W_MIX_B = 64'hFEDC_BA98_7654_3210;

    typedef struct packed {
        logic [ddi_pkg::WORD_W-1:0] w0;
        logic [ddi_pkg::WORD_W-1:0] w1;
        logic [ddi_pkg::WORD_W-1:0] w2;
        logic [ddi_pkg::WORD_W-1:0] w3;
    } digest_t;

    typedef struct packed {
        digest_t          key;
        logic             typed;
        ddi_pkg::result_t want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 18;

    // Ids are handed out in order of arrival, so most rows can be read off directly.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{W_ZERO, W_ZERO, W_ZERO, W_ZERO},   1'b1, '{1'b0, 10'd0, 1'b0}},
        '{'{W_ONES, W_ONES, W_ONES, W_ONES},   1'b1, '{1'b0, 10'd1, 1'b0}},
        '{'{W_ZERO, W_ZERO, W_ZERO, W_ZERO},   1'b1, '{1'b1, 10'd0, 1'b0}},
        '{'{W_ONES, W_ONES, W_ONES, W_ONES},   1'b1, '{1'b1, 10'd1, 1'b0}},
        '{'{W_ONES, W_ONES, W_ONES, W_NOLOW},  1'b1, '{1'b0, 10'd2, 1'b0}},
        '{'{W_ONES, W_ONES, W_NOTOP, W_ONES},  1'b1, '{1'b0, 10'd3, 1'b0}},
        '{'{W_ONES, W_ZERO, W_ONES, W_ONES},   1'b1, '{1'b0, 10'd4, 1'b0}},
        '{'{W_LOW1, W_ZERO, W_ZERO, W_ZERO},   1'b1, '{1'b0, 10'd5, 1'b0}},
        '{'{W_ZERO, W_ZERO, W_ZERO, W_TOP1},   1'b1, '{1'b0, 10'd6, 1'b0}},
        '{'{W_ALT_A, W_ALT_5, W_ALT_A, W_ALT_5}, 1'b1, '{1'b0, 10'd7, 1'b0}},
        '{'{W_ALT_5, W_ALT_A, W_ALT_5, W_ALT_A}, 1'b1, '{1'b0, 10'd8, 1'b0}},
        '{'{W_ONES, W_ONES, W_ONES, W_NOLOW},  1'b0, '{1'b0, 10'd0, 1'b0}},
        '{'{W_ZERO, W_ZERO, W_ZERO, W_TOP1},   1'b0, '{1'b0, 10'd0, 1'b0}},
        '{'{W_ALT_A, W_ALT_5, W_ALT_A, W_ALT_5}, 1'b0, '{1'b0, 10'd0, 1'b0}},
        '{'{W_LOW1, W_ZERO, W_ZERO, W_ZERO},   1'b0, '{1'b0, 10'd0, 1'b0}},
        '{'{W_ONES, W_ZERO, W_ONES, W_ONES},   1'b0, '{1'b0, 10'd0, 1'b0}},
        '{'{W_MIX_A, W_MIX_B, W_MIX_B, W_MIX_A}, 1'b0, '{1'b0, 10'd0, 1'b0}},
        '{'{W_MIX_A, W_MIX_B, W_MIX_B, W_MIX_A}, 1'b0, '{1'b0, 10'd0, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    ddi_digest_if digest_bus ();
    ddi_result_if result_bus ();

    digest_dedup_index #(
        .CAPACITY(ddi_pkg::CAPACITY)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .digest (digest_bus),
        .result (result_bus)
    );

    always #1 clk = ~clk;

    digest_t          stored_digests [ddi_pkg::CAPACITY];
    int unsigned      stored_count = 0;
    ddi_pkg::result_t expected_results [$];
    int unsigned      failures = 0;
    int unsigned      items_sent = 0;
    int unsigned      src_idle_pct = 12;
    int unsigned      sink_idle_pct = 77;

    // Look the digest up in the shadow index and store it on a miss with room left.
    function automatic ddi_pkg::result_t index_digest(input digest_t d);
        ddi_pkg::result_t r;
        r = '0;
        for (int unsigned i = 0; i < stored_count; i++)
        begin
            if (stored_digests[i] == d)
            begin
                r.is_duplicate = 1'b1;
                r.chunk_id     = i[ddi_pkg::ID_W-1:0];
                return r;
            end
        end
        if (stored_count >= ddi_pkg::CAPACITY)
        begin
            r.table_full = 1'b1;
        end
        else
        begin
            stored_digests[stored_count] = d;
            r.chunk_id = stored_count[ddi_pkg::ID_W-1:0];
            stored_count++;
        end
        return r;
    endfunction

    function automatic logic [ddi_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return W_ZERO;
            1: return W_ONES;
            2: return W_LOW1 << $urandom_range(ddi_pkg::WORD_W-1);
            3: return ~(W_LOW1 << $urandom_range(ddi_pkg::WORD_W-1));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic digest_t stored_pick();
        if ($urandom_range(7) == 0)
            return stored_digests[stored_count-1];
        return stored_digests[$urandom_range(stored_count-1)];
    endfunction

    // Called right after a rising edge; returns at the edge that accepts the transaction.
    task automatic send_digest(input digest_t d, input logic typed,
                               input ddi_pkg::result_t want);
        ddi_pkg::result_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            digest_bus.valid <= 1'b0;
            @(posedge clk);
        end
        digest_bus.valid     <= 1'b1;
        digest_bus.digest_w0 <= d.w0;
        digest_bus.digest_w1 <= d.w1;
        digest_bus.digest_w2 <= d.w2;
        digest_bus.digest_w3 <= d.w3;
        do
            @(posedge clk);
        while (digest_bus.ready !== 1'b1);
        predicted = index_digest(d);
        expected_results.push_back(typed ? want : predicted);
        items_sent++;
        if (items_sent == 500)
        begin
            src_idle_pct  = 77;
            sink_idle_pct = 12;
        end
        else if (items_sent == 1000)
        begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        ddi_pkg::result_t want;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else
        begin
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: is_duplicate=%0d chunk_id=%0d table_full=%0d",
                           result_bus.is_duplicate, result_bus.chunk_id,
                           result_bus.table_full);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_bus.is_duplicate !== want.is_duplicate)
                    begin
                        $error("is_duplicate: expected %0d, got %0d",
                               want.is_duplicate, result_bus.is_duplicate);
                        failures++;
                    end
                    if (result_bus.chunk_id !== want.chunk_id)
                    begin
                        $error("chunk_id: expected %0d, got %0d",
                               want.chunk_id, result_bus.chunk_id);
                        failures++;
                    end
                    if (result_bus.table_full !== want.table_full)
                    begin
                        $error("table_full: expected %0d, got %0d",
                               want.table_full, result_bus.table_full);
                        failures++;
                    end
                end
            end
            result_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("digest_dedup_index_tb NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        digest_t d;
        rst_n                <= 1'b0;
        digest_bus.valid     <= 1'b0;
        digest_bus.digest_w0 <= '0;
        digest_bus.digest_w1 <= '0;
        digest_bus.digest_w2 <= '0;
        digest_bus.digest_w3 <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_digest(DIRECTED[i].key, DIRECTED[i].typed, DIRECTED[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Fill the table mostly with fresh digests; once full, send fresh ones still more often.
            int unsigned roll;
            roll = $urandom_range(99);
            if (stored_count >= ddi_pkg::CAPACITY)
                roll = roll / 2;
            else
                roll = roll / 5;
            if (stored_count > 0 && roll < 4)
            begin
                d = stored_pick();
            end
            else if (stored_count > 0 && roll < 8)
            begin
                // near miss: one bit off a stored digest
                d = stored_pick();
                d = d ^ (digest_t'(1) << $urandom_range(ddi_pkg::KEY_W-1));
            end
            else
            begin
                d.w0 = pick_word();
                d.w1 = pick_word();
                d.w2 = pick_word();
                d.w3 = pick_word();
            end
            send_digest(d, 1'b0, '0);
        end
        digest_bus.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (ddi_pkg::CAPACITY + 8) @(posedge clk);
        if (failures == 0)
            $display("digest_dedup_index_tb OK");
        else
            $display("digest_dedup_index_tb NOT OK");
        $finish;
    end

endmodule
